// ----- design/nms_pkg.sv -----
package nms_pkg;

    // Item function codes.
    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_ADD    = 2'd1;
    localparam logic [1:0] FUNC_NORM   = 2'd2;
    localparam logic [1:0] FUNC_READ   = 2'd3;

    // Wave shape codes.
    localparam logic [1:0] SHAPE_SINE     = 2'd0;
    localparam logic [1:0] SHAPE_SAW      = 2'd1;
    localparam logic [1:0] SHAPE_SQUARE   = 2'd2;
    localparam logic [1:0] SHAPE_TRIANGLE = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_WAVE_SHAPE    = 2'd0;
    localparam logic [1:0] REG_TOTAL_SAMPLES = 2'd1;
    localparam logic [1:0] REG_RAMP_SAMPLES  = 2'd2;

    // Reset values and fixed arithmetic constants.
    localparam logic [1:0]  WAVE_SHAPE_RESET    = 2'd0;
    localparam logic [14:0] TOTAL_SAMPLES_RESET = 15'd16384;
    localparam logic [15:0] RAMP_SAMPLES_RESET  = 16'd2205;
    localparam logic [23:0] PEAK_RESET          = 24'd3;
    localparam logic [31:0] GAIN_RESET          = 32'd644245094;
    localparam logic [31:0] GAIN_NUM            = 32'd1932735283;
    localparam longint unsigned SINE_PI_Q30     = 64'd3373259426;

    // Shared divider width.
    localparam int DIV_W   = 32;
    localparam int DIV_CW  = $clog2(DIV_W);
    localparam int DIVS_W  = 24;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] start_index;
        logic [15:0] note_length;
        logic [23:0] phase_step;
        logic [15:0] velocity;
        logic [13:0] read_index;
    } nms_in_t;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic [13:0]        sample_index;
    } nms_out_t;

    typedef struct packed {
        logic [1:0]  wave_shape;
        logic [14:0] total_samples;
        logic [15:0] ramp_samples;
    } nms_cfg_t;

endpackage

// ----- design/note_mixing_synthesizer.sv -----
// Channel    Direction  Handshake          Word
// s_         in         s_valid / s_ready  nms_in_t: func, note and read fields
// m_         out        m_valid / m_ready  nms_out_t: sample_out, sample_index
// APB        in         psel / penable     wave_shape, total_samples, ramp_samples
//
// After reset the buffer is swept to zero with s_ready low.
// Clear sweeps the buffer to zero; normalize scans the buffer for its peak, then
// forms the gain in the shared divider.
// An add item renders one sample at a time; for a sample that lies in the attack
// or release ramp the shared divider forms the envelope.
// A read item reads the buffer and scales the sample, then waits while the output register is full.
// The block takes one item at a time; s_ready is high only when it is idle.
module note_mixing_synthesizer #(
    parameter int BUFFER_DEPTH     = 16384,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  nms_pkg::nms_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output nms_pkg::nms_out_t m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import nms_pkg::*;

    localparam int AW    = $clog2(BUFFER_DEPTH);
    localparam int POS_W = (AW + 1 > 17) ? AW + 1 : 17;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADD_ENV, S_ADD_DIV, S_ADD_RD, S_ADD_MUL1, S_ADD_MUL2,
        S_ADD_WR, S_NORM, S_GAIN_DIV, S_RD_MEM, S_RD_MUL, S_RD_OUT
    } state_t;

    state_t             state_reg;
    nms_cfg_t           cfg;
    logic [AW-1:0]      clr_reg;
    logic [16:0]        i_reg;
    logic [23:0]        phase_reg;
    logic [16:0]        env_reg;
    logic signed [15:0] wave_reg;
    logic [15:0]        start_reg;
    logic [15:0]        len_reg;
    logic [23:0]        step_reg;
    logic [15:0]        vel_reg;
    logic [13:0]        ridx_reg;
    logic [55:0]        prod_reg;
    logic [23:0]        peak_reg;
    logic [31:0]        gain_reg;
    logic [AW:0]        k_reg;
    logic               cmp_v_reg;
    logic               m_valid_reg;
    nms_out_t           m_data_reg;
    logic [23:0]        mem_rdata_reg;

    logic [23:0] mix_mem [BUFFER_DEPTH];

    // Configuration registers.
    nms_apb u_apb (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Oscillator from the phase accumulator.
    logic signed [15:0] wave;

    nms_wave #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_wave (
        .phase (phase_reg),
        .shape (cfg.wave_shape),
        .wave  (wave)
    );

    // Shared divider for the envelope and the output gain.
    logic              div_start;
    logic [DIV_W-1:0]  div_dividend;
    logic [DIVS_W-1:0] div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [DIV_W-1:0]  div_quot;

    nms_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Note position, limits and ramp regions.
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] limit;
    logic [15:0]      ramp;
    logic             note_done;
    logic             in_attack;
    logic             in_release;
    logic [16:0]      ramp_num;

    assign pos   = POS_W'(start_reg) + POS_W'(i_reg);
    assign limit = (POS_W'(cfg.total_samples) > POS_W'(BUFFER_DEPTH)) ?
                   POS_W'(BUFFER_DEPTH) : POS_W'(cfg.total_samples);
    assign ramp  = (cfg.ramp_samples == 16'd0) ? 16'd1 : cfg.ramp_samples;
    assign note_done  = (i_reg >= {1'b0, len_reg}) || (pos >= limit);
    assign in_attack  = i_reg < {1'b0, ramp};
    assign in_release = (18'(i_reg) + 18'(ramp)) > 18'(len_reg);
    assign ramp_num   = in_release ? ({1'b0, len_reg} - i_reg) : i_reg;

    // Magnitudes for the shared multiplier.
    logic [15:0] wave_mag;
    logic [23:0] samp_mag;
    logic [31:0] mul_a;
    logic [23:0] mul_b;

    assign wave_mag = wave_reg[15] ? 16'(-wave_reg) : wave_reg;
    assign samp_mag = mem_rdata_reg[23] ? 24'(-$signed(mem_rdata_reg)) : mem_rdata_reg;

    always_comb begin
        case (state_reg)
            S_ADD_MUL1: begin
                mul_a = 32'(env_reg);
                mul_b = 24'(wave_mag);
            end
            S_ADD_MUL2: begin
                mul_a = prod_reg[31:0];
                mul_b = 24'(vel_reg);
            end
            default: begin
                mul_a = gain_reg;
                mul_b = samp_mag;
            end
        endcase
    end

    // Rounded contribution and saturating mix.
    logic [48:0]        contrib_sum;
    logic [16:0]        contrib;
    logic signed [24:0] mix_sum;
    logic [23:0]        mix_sat;

    assign contrib_sum = {1'b0, prod_reg[47:0]} + (49'd1 << 31);
    assign contrib     = contrib_sum[48:32];
    assign mix_sum     = wave_reg[15] ?
                         25'($signed(mem_rdata_reg)) - $signed({8'd0, contrib}) :
                         25'($signed(mem_rdata_reg)) + $signed({8'd0, contrib});

    always_comb begin
        if (mix_sum > 25'sd8388607) begin
            mix_sat = 24'h7FFFFF;
        end else if (mix_sum < -25'sd8388608) begin
            mix_sat = 24'h800000;
        end else begin
            mix_sat = mix_sum[23:0];
        end
    end

    // Scaled read-out with saturation to 16 bits.
    logic [56:0]        rd_round;
    logic [40:0]        rd_mag;
    logic signed [15:0] rd_val;
    logic               rd_oob;

    assign rd_round = {1'b0, prod_reg} + 57'd32768;
    assign rd_mag   = rd_round[56:16];
    assign rd_oob   = 21'(ridx_reg) >= 21'(BUFFER_DEPTH);

    always_comb begin
        if (rd_oob) begin
            rd_val = 16'sd0;
        end else if (mem_rdata_reg[23]) begin
            rd_val = (rd_mag > 41'd32768) ? -16'sd32768 : 16'(-$signed(rd_mag[16:0]));
        end else begin
            rd_val = (rd_mag > 41'd32767) ? 16'sd32767 : $signed(rd_mag[15:0]);
        end
    end

    // Peak magnitude tracking for normalize.
    logic norm_exit;

    assign norm_exit = (state_reg == S_NORM) && (k_reg >= (AW+1)'(limit)) && !cmp_v_reg;

    // Divider requests.
    always_comb begin
        div_start    = 1'b0;
        div_dividend = {ramp_num[15:0], 16'd0};
        div_divisor  = 24'(ramp);
        if (state_reg == S_ADD_ENV) begin
            div_start = !note_done && (in_attack || in_release);
        end else if (norm_exit) begin
            div_start    = 1'b1;
            div_dividend = GAIN_NUM + 32'(peak_reg >> 1);
            div_divisor  = peak_reg;
        end
    end

    // Buffer memory ports.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [23:0]   mem_wdata;
    logic [AW-1:0] mem_raddr;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = pos[AW-1:0];
        mem_wdata = mix_sat;
        if (state_reg == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = 24'd0;
        end else if (state_reg == S_ADD_WR) begin
            mem_we = 1'b1;
        end
    end

    always_comb begin
        case (state_reg)
            S_NORM:   mem_raddr = k_reg[AW-1:0];
            S_RD_MEM: mem_raddr = AW'(ridx_reg);
            S_RD_MUL: mem_raddr = AW'(ridx_reg);
            S_RD_OUT: mem_raddr = AW'(ridx_reg);
            default:  mem_raddr = pos[AW-1:0];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mix_mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mix_mem[mem_raddr];
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            phase_reg   <= '0;
            peak_reg    <= PEAK_RESET;
            gain_reg    <= GAIN_RESET;
            m_valid_reg <= 1'b0;
            cmp_v_reg   <= 1'b0;
        end else begin
            // The output word leaves; the read-out state sets valid itself.
            if (m_valid_reg && m_ready && (state_reg != S_RD_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(BUFFER_DEPTH - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        start_reg <= s_data.start_index;
                        len_reg   <= s_data.note_length;
                        step_reg  <= s_data.phase_step;
                        vel_reg   <= s_data.velocity;
                        ridx_reg  <= s_data.read_index;
                        case (s_data.func)
                            FUNC_CLEAR: begin
                                clr_reg   <= '0;
                                state_reg <= S_CLEAR;
                            end
                            FUNC_ADD: begin
                                i_reg     <= '0;
                                phase_reg <= '0;
                                state_reg <= S_ADD_ENV;
                            end
                            FUNC_NORM: begin
                                k_reg     <= '0;
                                cmp_v_reg <= 1'b0;
                                peak_reg  <= PEAK_RESET;
                                state_reg <= S_NORM;
                            end
                            default: state_reg <= S_RD_MEM;
                        endcase
                    end
                end
                S_ADD_ENV: begin
                    if (note_done) begin
                        state_reg <= S_IDLE;
                    end else if (in_attack || in_release) begin
                        state_reg <= S_ADD_DIV;
                    end else begin
                        env_reg   <= 17'd65536;
                        state_reg <= S_ADD_RD;
                    end
                end
                S_ADD_DIV: begin
                    if (div_done) begin
                        env_reg   <= div_quot[16:0];
                        state_reg <= S_ADD_RD;
                    end
                end
                S_ADD_RD: begin
                    wave_reg  <= wave;
                    state_reg <= S_ADD_MUL1;
                end
                S_ADD_MUL1: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_ADD_MUL2;
                end
                S_ADD_MUL2: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_ADD_WR;
                end
                S_ADD_WR: begin
                    i_reg     <= i_reg + 1'b1;
                    phase_reg <= phase_reg + step_reg;
                    state_reg <= S_ADD_ENV;
                end
                S_NORM: begin
                    if (cmp_v_reg && (samp_mag > peak_reg)) begin
                        peak_reg <= samp_mag;
                    end
                    if (k_reg < (AW+1)'(limit)) begin
                        k_reg     <= k_reg + 1'b1;
                        cmp_v_reg <= 1'b1;
                    end else begin
                        cmp_v_reg <= 1'b0;
                        if (!cmp_v_reg) begin
                            state_reg <= S_GAIN_DIV;
                        end
                    end
                end
                S_GAIN_DIV: begin
                    if (div_done) begin
                        gain_reg  <= div_quot;
                        state_reg <= S_IDLE;
                    end
                end
                S_RD_MEM: begin
                    state_reg <= S_RD_MUL;
                end
                S_RD_MUL: begin
                    prod_reg  <= mul_a * mul_b;
                    state_reg <= S_RD_OUT;
                end
                S_RD_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.sample_out   <= rd_val;
                        m_data_reg.sample_index <= ridx_reg;
                        m_valid_reg             <= 1'b1;
                        state_reg               <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The buffer is written only by the clear sweep or the mix step.
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("buffer written while idle");

    // The peak never drops below its floor.
    a_peak_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        peak_reg >= PEAK_RESET)
        else $error("peak below floor");

    // The divider is never restarted while it is working.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    // A read item goes straight to the buffer read.
    a_read_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.func == FUNC_READ)) |=> (state_reg == S_RD_MEM))
        else $error("read item not started");

endmodule

// ----- design/nms_div.sv -----
module nms_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [nms_pkg::DIV_W-1:0]  dividend,
    input  logic [nms_pkg::DIVS_W-1:0] divisor,
    output logic                       busy,
    output logic                       done,
    output logic [nms_pkg::DIV_W-1:0]  quotient
);
    import nms_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DIV_W-1:0]  quo_reg;
    logic [DIVS_W-1:0] dvs_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [DIVS_W:0]   rem_shift;
    logic              fits;

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign rem_shift = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits      = rem_shift >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= dividend;
                dvs_reg  <= divisor;
                rem_reg  <= '0;
                quo_reg  <= '0;
            end else if (busy_reg) begin
                dvd_reg <= {dvd_reg[DIV_W-2:0], 1'b0};
                quo_reg <= {quo_reg[DIV_W-2:0], fits};
                rem_reg <= fits ? DIVS_W'(rem_shift - {1'b0, dvs_reg})
                                : rem_shift[DIVS_W-1:0];
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CW'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/nms_wave.sv -----
module nms_wave #(
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  logic [23:0]        phase,
    input  logic [1:0]         shape,
    output logic signed [15:0] wave
);
    import nms_pkg::*;

    localparam int TAW = $clog2(SINE_TABLE_DEPTH);

    // Quarter sine entry by a fixed-point Taylor series, worked out at elaboration.
    function automatic logic [15:0] sine_entry(input int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned sum;
        x    = (SINE_PI_Q30 * longint'(k)) / (2 * SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 6;   sum = sum - term;
        term = ((term * x2) >> 30) / 20;  sum = sum + term;
        term = ((term * x2) >> 30) / 42;  sum = sum - term;
        term = ((term * x2) >> 30) / 72;  sum = sum + term;
        term = ((term * x2) >> 30) / 110; sum = sum - term;
        term = ((term * x2) >> 30) / 156; sum = sum + term;
        term = ((term * x2) >> 30) / 210; sum = sum - term;
        return 16'((sum * 64'd32767 + (64'd1 << 29)) >> 30);
    endfunction

    logic [15:0] sine_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
        assign sine_rom[k] = sine_entry(k);
    end

    logic [1:0]         quad;
    logic [TAW-1:0]     idx;
    logic [TAW:0]       mirror_idx;
    logic signed [15:0] sine_up;
    logic signed [15:0] sine_down;
    logic signed [17:0] tri_lin;
    logic signed [17:0] tri_val;

    assign quad       = phase[23:22];
    assign idx        = phase[21 -: TAW];
    assign mirror_idx = (TAW+1)'(SINE_TABLE_DEPTH) - {1'b0, idx};
    assign sine_up    = $signed(sine_rom[idx]);
    // At the quarter point the mirrored index runs past the table, so the full-scale value is given directly.
    assign sine_down  = (idx == '0) ? 16'sd32767
                                    : $signed(sine_rom[mirror_idx[TAW-1:0]]);
    assign tri_lin    = $signed({1'b0, phase[23:7]});

    // Triangle before clamping to the 16-bit range.
    always_comb begin
        if (phase < 24'h400000) begin
            tri_val = tri_lin;
        end else if (phase < 24'hC00000) begin
            tri_val = 18'sd65536 - tri_lin;
        end else begin
            tri_val = tri_lin - 18'sd131072;
        end
    end

    always_comb begin
        case (shape)
            SHAPE_SINE: begin
                case (quad)
                    2'd0:    wave = sine_up;
                    2'd1:    wave = sine_down;
                    2'd2:    wave = -sine_up;
                    default: wave = -sine_down;
                endcase
            end
            SHAPE_SAW:    wave = $signed(phase[23:8]);
            SHAPE_SQUARE: wave = phase[23] ? -16'sd32767 : 16'sd32767;
            default: begin
                if (tri_val > 18'sd32767) begin
                    wave = 16'sd32767;
                end else if (tri_val < -18'sd32768) begin
                    wave = -16'sd32768;
                end else begin
                    wave = tri_val[15:0];
                end
            end
        endcase
    end

endmodule

// ----- design/nms_apb.sv -----
module nms_apb (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output nms_pkg::nms_cfg_t cfg
);
    import nms_pkg::*;

    logic [1:0]  wave_shape_reg;
    logic [14:0] total_samples_reg;
    logic [15:0] ramp_samples_reg;
    logic [1:0]  reg_index;

    assign reg_index = paddr[3:2];
    assign pready    = 1'b1;

    // Register writes in the access phase; unknown indexes are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_shape_reg    <= WAVE_SHAPE_RESET;
            total_samples_reg <= TOTAL_SAMPLES_RESET;
            ramp_samples_reg  <= RAMP_SAMPLES_RESET;
        end else if (psel && penable && pwrite) begin
            case (reg_index)
                REG_WAVE_SHAPE:    wave_shape_reg    <= pwdata[1:0];
                REG_TOTAL_SAMPLES: total_samples_reg <= pwdata[14:0];
                REG_RAMP_SAMPLES:  ramp_samples_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        case (reg_index)
            REG_WAVE_SHAPE:    prdata = {30'd0, wave_shape_reg};
            REG_TOTAL_SAMPLES: prdata = {17'd0, total_samples_reg};
            REG_RAMP_SAMPLES:  prdata = {16'd0, ramp_samples_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.wave_shape    = wave_shape_reg;
    assign cfg.total_samples = total_samples_reg;
    assign cfg.ramp_samples  = ramp_samples_reg;

endmodule

// ----- bench/note_mixing_checker.sv -----
`timescale 1ns / 100ps

module note_mixing_checker
    import nms_pkg::*;
#(
    parameter int DEPTH = 16384,
    parameter int TDEPTH = 256
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  nms_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  nms_out_t m_data,
    input  logic     psel,
    input  logic     penable,
    input  logic     pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int       fail_count,
    output int       pending_reads,
    output int       reads_seen
);

    int mix_samples [DEPTH];
    int sine_table [TDEPTH];
    logic [1:0]  shape_reg;
    int unsigned total_reg;
    int unsigned ramp_reg;
    longint unsigned gain_reg;
    nms_out_t expected_samples [$];

    // Builds the quarter-wave sine table from a Taylor series in Q30.
    function automatic void build_table();
        longint unsigned x, x2, term, sum;
        for (int k = 0; k < TDEPTH; k++) begin
            x = (SINE_PI_Q30 * k) / (2 * TDEPTH);
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 7; n++) begin
                term = (term * x2) >> 30;
                term = term / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum = sum - term;
                else sum = sum + term;
            end
            sine_table[k] = int'((sum * 32767 + (64'd1 << 29)) >> 30);
        end
    endfunction

    function automatic int quarter_value(int unsigned frac, bit mirror);
        int unsigned idx;
        idx = int'((longint'(frac) * TDEPTH) >> 22);
        if (mirror) begin
            idx = TDEPTH - idx;
            if (idx >= TDEPTH) return 32767;
        end
        if (idx >= TDEPTH) idx = TDEPTH - 1;
        return sine_table[idx];
    endfunction

    function automatic int clip16(int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic int oscillator(int unsigned p);
        int unsigned quad, frac;
        quad = (p >> 22) & 3;
        frac = p & 32'h3FFFFF;
        case (shape_reg)
            SHAPE_SINE: begin
                if (quad == 0) return quarter_value(frac, 0);
                if (quad == 1) return quarter_value(frac, 1);
                if (quad == 2) return -quarter_value(frac, 0);
                return -quarter_value(frac, 1);
            end
            SHAPE_SAW: begin
                if (p < 32'h800000) return int'(p >> 8);
                return int'(p >> 8) - 65536;
            end
            SHAPE_SQUARE: return (p < 32'h800000) ? 32767 : -32767;
            default: begin
                if (p < 32'h400000) return clip16(int'(p >> 7));
                if (p < 32'hC00000) return clip16(65536 - int'(p >> 7));
                return clip16(int'(p >> 7) - 131072);
            end
        endcase
    endfunction

    function automatic int unsigned used_limit();
        return (total_reg > DEPTH) ? DEPTH : total_reg;
    endfunction

    // Renders one note into the mix, saturating at 24 bits.
    function automatic void render_note(nms_in_t w);
        longint r, env, len, i, acc;
        longint unsigned mag;
        int unsigned phase, pos;
        int s;
        r = (ramp_reg == 0) ? 1 : ramp_reg;
        len = w.note_length;
        phase = 0;
        for (i = 0; i < len && w.start_index + i < used_limit(); i++) begin
            pos = w.start_index + i;
            env = 65536;
            if (i < r) env = (i * 65536) / r;
            if (i > len - r) env = ((len - i) * 65536) / r;
            if (env < 0) env = 0;
            if (env > 65536) env = 65536;
            s = oscillator(phase);
            mag = longint'(s < 0 ? -s : s) * env * w.velocity;
            mag = (mag + (64'd1 << 31)) >> 32;
            acc = mix_samples[pos] + (s < 0 ? -longint'(mag) : longint'(mag));
            if (acc > 8388607) acc = 8388607;
            if (acc < -8388608) acc = -8388608;
            mix_samples[pos] = int'(acc);
            phase = (phase + w.phase_step) & 32'hFFFFFF;
        end
    endfunction

    function automatic void find_gain();
        longint unsigned peak, a;
        peak = 3;
        for (int i = 0; i < used_limit(); i++) begin
            a = (mix_samples[i] < 0) ? -mix_samples[i] : mix_samples[i];
            if (a > peak) peak = a;
        end
        gain_reg = (GAIN_NUM + peak / 2) / peak;
    endfunction

    function automatic logic signed [15:0] scaled_sample(int unsigned idx);
        longint unsigned mag;
        longint v;
        int s;
        if (idx >= DEPTH) return 0;
        s = mix_samples[idx];
        mag = longint'(s < 0 ? -s : s) * gain_reg;
        mag = (mag + (64'd1 << 15)) >> 16;
        if (mag > 40000) mag = 40000;
        v = (s < 0) ? -longint'(mag) : longint'(mag);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    assign pending_reads = expected_samples.size();

    // Follows register writes and input words, then checks each output word.
    always @(posedge aclk) begin
        nms_out_t want, rd;
        if (!aresetn) begin
            foreach (mix_samples[i]) mix_samples[i] = 0;
            build_table();
            shape_reg = WAVE_SHAPE_RESET;
            total_reg = TOTAL_SAMPLES_RESET;
            ramp_reg = RAMP_SAMPLES_RESET;
            gain_reg = GAIN_RESET;
            expected_samples.delete();
            fail_count = 0;
            reads_seen = 0;
        end else begin
            if (psel && penable && pwrite) begin
                case (paddr[3:2])
                    REG_WAVE_SHAPE: shape_reg = pwdata[1:0];
                    REG_TOTAL_SAMPLES: total_reg = pwdata[14:0];
                    REG_RAMP_SAMPLES: ramp_reg = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                case (s_data.func)
                    FUNC_CLEAR: foreach (mix_samples[i]) mix_samples[i] = 0;
                    FUNC_ADD: render_note(s_data);
                    FUNC_NORM: find_gain();
                    default: begin
                        rd.sample_index = s_data.read_index;
                        rd.sample_out = scaled_sample(s_data.read_index);
                        expected_samples.push_back(rd);
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                reads_seen++;
                if (expected_samples.size() == 0) begin
                    report_mismatch("unexpected word", m_data.sample_index, -1);
                end else begin
                    want = expected_samples.pop_front();
                    if (m_data.sample_out !== want.sample_out)
                        report_mismatch("sample_out", m_data.sample_out, want.sample_out);
                    if (m_data.sample_index !== want.sample_index)
                        report_mismatch("sample_index", m_data.sample_index,
                                        want.sample_index);
                end
            end
        end
    end

endmodule

// ----- bench/note_mixing_synthesizer_test.sv -----
`timescale 1ns / 100ps

module note_mixing_synthesizer_test;
    import nms_pkg::*;

    localparam int IDLE_LIMIT = 4000000;

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    nms_in_t s_data;
    logic m_valid;
    logic m_ready;
    nms_out_t m_data;
    logic psel, penable, pwrite, pready;
    logic [3:0] paddr;
    logic [31:0] pwdata, prdata;
    int fail_count, pending_reads, reads_seen;
    int words_sent;
    bit hold_output;
    int idle_cycles = 0;

    note_mixing_synthesizer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    note_mixing_checker checker_0 (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .fail_count(fail_count), .pending_reads(pending_reads),
        .reads_seen(reads_seen)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // Watchdog: counts cycles with no accepted word on any channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog expired");
            $display("simulation failed");
            $finish;
        end
    end

    // The receiver stalls at random, or for a long stretch when asked.
    initial begin
        int gap;
        m_ready = 0;
        forever begin
            @(negedge aclk);
            if (hold_output) begin
                m_ready <= 0;
                repeat (300) @(negedge aclk);
                hold_output = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    task automatic write_reg(logic [1:0] index, logic [31:0] value);
        @(negedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {index, 2'b00}; pwdata <= value;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Offers one word; valid drops only when a gap comes before the next word.
    task automatic send_word(nms_in_t w, bit pace);
        int gap;
        gap = pace ? $urandom_range(0, 12) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_data <= w;
        s_valid <= 1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    function automatic nms_in_t make_word(logic [1:0] f);
        nms_in_t w;
        w = ($bits(nms_in_t))'({$urandom, $urandom, $urandom});
        w.func = f;
        return w;
    endfunction

    // A short note with random content; most land inside a small buffer window.
    function automatic nms_in_t make_note();
        nms_in_t w;
        w = make_word(FUNC_ADD);
        w.start_index = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 80));
        w.note_length = $urandom_range(0, 9) == 0 ? 16'($urandom_range(0, 400))
                                                  : 16'($urandom_range(0, 60));
        return w;
    endfunction

    // Drops valid, then waits for every read word and for the block to go idle.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 0;
        while (pending_reads != 0 || !s_ready) @(posedge aclk);
        repeat (100) @(negedge aclk);
    endtask

    initial begin
        nms_in_t w;
        int pick;
        s_valid = 0;
        s_data = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        hold_output = 0;
        words_sent = 0;
        aresetn = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1;

        // Reads before anything was rendered, at the extremes of the index.
        w = make_word(FUNC_READ); w.read_index = '0; send_word(w, 0);
        w.read_index = '1; send_word(w, 0);
        w = make_word(FUNC_NORM); send_word(w, 0);
        w = make_word(FUNC_READ); w.read_index = 14'd5; send_word(w, 0);

        // Small buffer and short ramps keep notes and scans brief.
        wait_drained();
        write_reg(REG_TOTAL_SAMPLES, 128);
        write_reg(REG_RAMP_SAMPLES, 0);
        write_reg(REG_WAVE_SHAPE, SHAPE_SQUARE);
        // Full-scale note at maximum velocity, mixed three times; note past the end.
        w = make_word(FUNC_ADD);
        w.start_index = 0; w.note_length = 40; w.phase_step = '1; w.velocity = '1;
        repeat (3) send_word(w, 0);
        w.start_index = 120; w.note_length = 20; w.phase_step = 0;
        send_word(w, 0);
        w.start_index = '1; w.note_length = '1; send_word(w, 0);
        w = make_word(FUNC_NORM); send_word(w, 0);
        for (int i = 0; i < 4; i++) begin
            w = make_word(FUNC_READ); w.read_index = 14'(i * 41); send_word(w, 0);
        end
        w = make_word(FUNC_READ); w.read_index = 14'd127; send_word(w, 0);
        w = make_word(FUNC_CLEAR); send_word(w, 0);
        w = make_word(FUNC_READ); w.read_index = 14'd3; send_word(w, 0);

        // Random phases across all shapes and several ramp and size settings.
        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            write_reg(REG_WAVE_SHAPE, phase % 4);
            write_reg(REG_RAMP_SAMPLES, phase == 5 ? 32'hFFFF : $urandom_range(1, 30));
            write_reg(REG_TOTAL_SAMPLES, phase == 4 ? 32'h7FFF
                                        : phase == 3 ? 0 : $urandom_range(64, 256));
            if (phase == 2) hold_output = 1;
            for (int n = 0; n < 15; n++) begin
                pick = $urandom_range(0, 9);
                if (phase == 4 && n > 1) pick = 9;
                if (pick < 4) w = make_note();
                else if (pick < 5) w = make_word(FUNC_NORM);
                else if (pick < 6 && n % 7 == 0) w = make_word(FUNC_CLEAR);
                else begin
                    w = make_word(FUNC_READ);
                    if ($urandom_range(0, 3) != 0) w.read_index = 14'($urandom_range(0, 90));
                end
                if (phase == 4 && n == 1) w = make_word(FUNC_NORM);
                send_word(w, n % 5 != 0);
            end
        end

        wait_drained();
        $display("Sent %0d input words over four wave shapes and several sizes,", words_sent);
        $display("checked %0d read words.", reads_seen);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/nms_pkg.sv
design/nms_div.sv
design/nms_wave.sv
design/nms_apb.sv
design/note_mixing_synthesizer.sv
bench/note_mixing_checker.sv
bench/note_mixing_synthesizer_test.sv
